/* hw/rtl/tmph_pkg.sv */
package tmph_pkg;

   // field widths of the result channel
   localparam int MID_W      = 12;
   localparam int HEAD_W     = 9;
   localparam int HEIGHT_W   = 12;
   localparam int RSP_FLD_W  = 2 * MID_W + HEAD_W;
   localparam int RSP_W      = ((RSP_FLD_W + 7) / 8) * 8;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

   // degree chain: one cell per whole degree inside the first octant
   localparam int F_W        = 6;
   localparam int OCT_DEG    = 45;
   localparam int CELL_CNT   = 44;

   // coordinate bits plus trig fraction bits always total this width
   localparam int TRIG_TOTAL = 62;

   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

   // Taylor term divisors (2i)(2i+1) and (2i-1)(2i), i = 1..12
   localparam logic [63:0] SIN_DIV [0:11] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
      64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
   localparam logic [63:0] COS_DIV [0:11] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
      64'd132, 64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   typedef enum logic [1:0] {
      QUAD_E,
      QUAD_N,
      QUAD_W,
      QUAD_S
   } tmph_quad_type;

   // sideband that travels with each item down the chain
   typedef struct packed {
      logic               live;
      logic               pose_valid;
      logic               swap;
      logic               exact;
      logic               eq;
      tmph_quad_type      quad;
      logic [MID_W-1:0]   mid_x;
      logic [MID_W-1:0]   mid_y;
   } tmph_side_type;

   // Q60 product, kept to 64 bits
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // sin or cos of k degrees in Q60 by a 13-term Taylor series (elaboration only)
   function automatic logic [63:0] trig_q60(input int unsigned k, input logic want_cos);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] s;
      logic [63:0] c;
      x  = (PI_Q60 / 64'd180) * 64'(k);
      x2 = mul_q60(x, x);
      ts = x;
      tc = ONE_Q60;
      s  = x;
      c  = ONE_Q60;
      for (int i = 0; i < 12; i++) begin
         ts = mul_q60(ts, x2) / SIN_DIV[i];
         tc = mul_q60(tc, x2) / COS_DIV[i];
         if (i[0] == 1'b0) begin
            s = s - ts;
            c = c - tc;
         end else begin
            s = s + ts;
            c = c + tc;
         end
      end
      return want_cos ? c : s;
   endfunction

endpackage

/* hw/rtl/two_marker_pose_heading_core.sv */
// Pose of a robot from the centroids of its front and back tags.
// Input stream (req_*): one transfer carries both centroids in fixed point;
// the y coordinates are flipped against image_height before use.
// Result stream (rsp_*): midpoint in whole pixels and the heading of the
// back-to-front vector in whole degrees (0 east, 90 north), truncated.
// rsp_tuser is low when the tags coincide; heading is then zero.
// csr_we/csr_wdata write image_height (reset 480); write only while idle.
// Path: an item passes through one folding stage, a chain of 44 degree
// cells (one per whole degree of the first octant, one cross-multiply
// compare each) and the output register.
// Throughput: one item per cycle while the skid entry is empty.
// Reset empties the chain and the output side and restores image_height.
// When the receiver stalls, the output register holds its item and a one-
// entry skid takes the next; once the skid is full the chain freezes and
// req_tready stays low until the next output transfer empties the skid.
module two_marker_pose_heading_core #(
   parameter int COORD_INT_BITS  = 12,
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tmph_pkg::HEIGHT_W-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // front_x, front_y, back_x, back_y, zero fill
   input  logic [((4 * (COORD_INT_BITS + COORD_FRAC_BITS) + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mid_x, mid_y, heading_deg, zero fill
   output logic [tmph_pkg::RSP_W-1:0]        rsp_tdata,
   // pose_valid
   output logic                              rsp_tuser
);
   import tmph_pkg::*;

   localparam int CB = COORD_INT_BITS + COORD_FRAC_BITS;

   logic [HEIGHT_W-1:0] height_ff;
   logic                pipe_en;

   logic [CB-1:0]       n_chain [0:CELL_CNT];
   logic [CB-1:0]       m_chain [0:CELL_CNT];
   logic [F_W-1:0]      f_chain [0:CELL_CNT];
   tmph_side_type       side_chain [0:CELL_CNT];

   // image height register
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         height_ff <= csr_wdata;
      end
   end

   assign req_tready = pipe_en;

   // fold into the first octant
   tmph_prep #(
      .COORD_BITS (CB),
      .FRAC_BITS  (COORD_FRAC_BITS)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .req_tvalid   (req_tvalid),
      .front_x      (req_tdata[CB-1:0]),
      .front_y      (req_tdata[2*CB-1:CB]),
      .back_x       (req_tdata[3*CB-1:2*CB]),
      .back_y       (req_tdata[4*CB-1:3*CB]),
      .image_height (height_ff),
      .n_o          (n_chain[0]),
      .m_o          (m_chain[0]),
      .side_o       (side_chain[0])
   );

   assign f_chain[0] = '0;

   // one cell per whole degree, 1 through 44
   for (genvar k = 1; k <= CELL_CNT; k++) begin : g_cell
      tmph_cell #(
         .COORD_BITS (CB),
         .DEG        (k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (pipe_en),
         .n_i    (n_chain[k-1]),
         .m_i    (m_chain[k-1]),
         .f_i    (f_chain[k-1]),
         .side_i (side_chain[k-1]),
         .n_o    (n_chain[k]),
         .m_o    (m_chain[k]),
         .f_o    (f_chain[k]),
         .side_o (side_chain[k])
      );
   end

   // heading unfold, output register and skid
   tmph_out u_out (
      .clock      (clock),
      .reset      (reset),
      .f_i        (f_chain[CELL_CNT]),
      .side_i     (side_chain[CELL_CNT]),
      .pipe_en    (pipe_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/tmph_prep.sv */
module tmph_prep #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          req_tvalid,
   input  logic [COORD_BITS-1:0]         front_x,
   input  logic [COORD_BITS-1:0]         front_y,
   input  logic [COORD_BITS-1:0]         back_x,
   input  logic [COORD_BITS-1:0]         back_y,
   input  logic [tmph_pkg::HEIGHT_W-1:0] image_height,
   output logic [COORD_BITS-1:0]         n_o,
   output logic [COORD_BITS-1:0]         m_o,
   output tmph_pkg::tmph_side_type       side_o
);
   import tmph_pkg::*;

   localparam int YW = COORD_BITS + 16;

   logic [COORD_BITS:0]       dx_s;
   logic [COORD_BITS:0]       dy_s;
   logic [COORD_BITS:0]       ndx;
   logic [COORD_BITS:0]       ndy;
   logic [COORD_BITS-1:0]     a_abs;
   logic [COORD_BITS-1:0]     b_abs;
   logic                      dx_pos;
   logic                      dx_neg;
   logic                      dy_pos;
   logic                      dy_neg;
   logic [COORD_BITS:0]       sx;
   logic [COORD_BITS+MID_W:0] sxw;
   logic [YW-1:0]             h2;
   logic [YW-1:0]             ysum;
   logic [YW-1:0]             ysh;

   logic [COORD_BITS-1:0]     n_in, n_ff;
   logic [COORD_BITS-1:0]     m_in, m_ff;
   tmph_side_type             side_in, side_ff;

   // difference vector, back tag to front tag, y already flipped
   always_comb begin
      dx_s   = {1'b0, front_x} - {1'b0, back_x};
      dy_s   = {1'b0, back_y} - {1'b0, front_y};
      ndx    = -dx_s;
      ndy    = -dy_s;
      a_abs  = dx_s[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
      b_abs  = dy_s[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];
      dx_neg = dx_s[COORD_BITS];
      dy_neg = dy_s[COORD_BITS];
      dx_pos = !dx_neg && (dx_s != '0);
      dy_pos = !dy_neg && (dy_s != '0);
   end

   // midpoints, truncated to whole pixels
   always_comb begin
      sx   = {1'b0, front_x} + {1'b0, back_x};
      sxw  = {{MID_W{1'b0}}, sx} >> (FRAC_BITS + 1);
      h2   = YW'(image_height) << (FRAC_BITS + 1);
      ysum = h2 - YW'(front_y) - YW'(back_y);
      ysh  = ysum >> (FRAC_BITS + 1);
   end

   // fold into the first octant, note quadrant and exact-angle cases
   always_comb begin
      side_in            = '0;
      side_in.live       = req_tvalid;
      side_in.pose_valid = (a_abs != '0) || (b_abs != '0);
      side_in.swap       = b_abs > a_abs;
      side_in.eq         = a_abs == b_abs;
      side_in.exact      = side_in.swap ? (a_abs == '0) : ((b_abs == '0) || side_in.eq);
      side_in.mid_x      = sxw[MID_W-1:0];
      side_in.mid_y      = ysum[YW-1] ? '0 : ysh[MID_W-1:0];
      if (dx_pos && !dy_neg) begin
         side_in.quad = QUAD_E;
      end else if (!dx_pos && dy_pos) begin
         side_in.quad = QUAD_N;
      end else if (dx_neg && !dy_pos) begin
         side_in.quad = QUAD_W;
      end else begin
         side_in.quad = QUAD_S;
      end
      n_in = side_in.swap ? a_abs : b_abs;
      m_in = side_in.swap ? b_abs : a_abs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.live <= 1'b0;
      end else if (en) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         m_ff <= m_in;
      end
   end

   assign n_o    = n_ff;
   assign m_o    = m_ff;
   assign side_o = side_ff;

endmodule

/* hw/rtl/tmph_cell.sv */
module tmph_cell #(
   parameter int COORD_BITS = 16,
   parameter int DEG        = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [COORD_BITS-1:0]    n_i,
   input  logic [COORD_BITS-1:0]    m_i,
   input  logic [tmph_pkg::F_W-1:0] f_i,
   input  tmph_pkg::tmph_side_type  side_i,
   output logic [COORD_BITS-1:0]    n_o,
   output logic [COORD_BITS-1:0]    m_o,
   output logic [tmph_pkg::F_W-1:0] f_o,
   output tmph_pkg::tmph_side_type  side_o
);
   import tmph_pkg::*;

   localparam int TRIG_Q     = TRIG_TOTAL - COORD_BITS;
   localparam int TRIG_SHIFT = 60 - TRIG_Q;

   localparam logic [63:0] SIN_Q60 = trig_q60(DEG, 1'b0);
   localparam logic [63:0] COS_Q60 = trig_q60(DEG, 1'b1);
   localparam logic [TRIG_Q-1:0] SIN_K =
      TRIG_Q'((SIN_Q60 + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);
   localparam logic [TRIG_Q-1:0] COS_K =
      TRIG_Q'((COS_Q60 + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);

   logic [TRIG_TOTAL-1:0] lhs;
   logic [TRIG_TOTAL-1:0] rhs;
   logic [F_W-1:0]        f_in, f_ff;
   logic [COORD_BITS-1:0] n_ff;
   logic [COORD_BITS-1:0] m_ff;
   tmph_side_type         side_ff;

   // angle >= DEG degrees  <=>  n*cos >= m*sin ; later cells overwrite
   always_comb begin
      lhs  = TRIG_TOTAL'(n_i) * TRIG_TOTAL'(COS_K);
      rhs  = TRIG_TOTAL'(m_i) * TRIG_TOTAL'(SIN_K);
      f_in = (lhs >= rhs) ? F_W'(DEG) : f_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.live <= 1'b0;
      end else if (en) begin
         side_ff <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_i;
         m_ff <= m_i;
         f_ff <= f_in;
      end
   end

   assign n_o    = n_ff;
   assign m_o    = m_ff;
   assign f_o    = f_ff;
   assign side_o = side_ff;

endmodule

/* hw/rtl/tmph_out.sv */
module tmph_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tmph_pkg::F_W-1:0]   f_i,
   input  tmph_pkg::tmph_side_type    side_i,
   output logic                       pipe_en,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tmph_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tuser
);
   import tmph_pkg::*;

   logic [F_W-1:0]       g;
   logic [9:0]           g10;
   logic [9:0]           oct10;
   logic [9:0]           head10;
   logic [HEAD_W-1:0]    heading;
   logic [RSP_FLD_W-1:0] pipe_data;
   logic                 out_take;

   logic                 out_vld_in, out_vld_ff;
   logic                 skid_vld_in, skid_vld_ff;
   logic                 out_load, skid_load;
   logic [RSP_FLD_W-1:0] out_data_in, out_data_ff;
   logic                 out_pv_in, out_pv_ff;
   logic [RSP_FLD_W-1:0] skid_data_ff;
   logic                 skid_pv_ff;

   // unfold the octant angle into the full circle
   always_comb begin
      g     = side_i.eq ? F_W'(OCT_DEG) : f_i;
      g10   = 10'(g);
      if (side_i.swap) begin
         oct10 = side_i.exact ? (10'd90 - g10) : (10'd89 - g10);
      end else begin
         oct10 = g10;
      end
      case (side_i.quad)
         QUAD_E:  head10 = oct10;
         QUAD_N:  head10 = side_i.exact ? (10'd180 - oct10) : (10'd179 - oct10);
         QUAD_W:  head10 = 10'd180 + oct10;
         QUAD_S:  head10 = side_i.exact ? (10'd360 - oct10) : (10'd359 - oct10);
         default: head10 = '0;
      endcase
      heading   = side_i.pose_valid ? head10[HEAD_W-1:0] : '0;
      pipe_data = {heading, side_i.mid_y, side_i.mid_x};
   end

   // output register plus one skid entry; the chain moves while the skid is empty
   always_comb begin
      out_take    = out_vld_ff && rsp_tready;
      pipe_en     = !skid_vld_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_load    = 1'b0;
      skid_load   = 1'b0;
      out_data_in = pipe_data;
      out_pv_in   = side_i.pose_valid;
      if (skid_vld_ff) begin
         if (out_take) begin
            out_load    = 1'b1;
            out_data_in = skid_data_ff;
            out_pv_in   = skid_pv_ff;
            skid_vld_in = 1'b0;
         end
      end else if (side_i.live) begin
         if (!out_vld_ff || out_take) begin
            out_load   = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            skid_load   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (out_take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
         out_pv_ff   <= out_pv_in;
      end
      if (skid_load) begin
         skid_data_ff <= pipe_data;
         skid_pv_ff   <= side_i.pose_valid;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_FLD_W){1'b0}}, out_data_ff};
   assign rsp_tuser  = out_pv_ff;

`ifndef ASSERT_OFF
   // the skid only holds an item behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry without output entry");

   // a full skid with no transfer stays full
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_tready) |=> skid_vld_ff)
      else $error("skid entry lost while output stalled");

   // heading stays within one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_data_ff[RSP_FLD_W-1:2*MID_W] < 9'd360))
      else $error("heading out of range");

   // coincident tags report heading zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_pv_ff) |-> (out_data_ff[RSP_FLD_W-1:2*MID_W] == '0))
      else $error("invalid pose with nonzero heading");
`endif

endmodule

/* bench/tb_two_marker_pose_heading_core.sv */
`timescale 1ns / 100ps

module tb_two_marker_pose_heading_core;

   localparam int MID_W       = tmph_pkg::MID_W;
   localparam int HEAD_W      = tmph_pkg::HEAD_W;
   localparam int HEIGHT_W    = tmph_pkg::HEIGHT_W;
   localparam int RSP_W       = tmph_pkg::RSP_W;
   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 4;
   localparam int REQ_W       = 4 * COORD_BITS;
   localparam int TRIG_SHIFT  = COORD_BITS - 2;
   localparam int DEG_CELLS   = 44;
   localparam int LATENCY     = 46;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 275;
   localparam int DIR_ROWS    = 21;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SHOW_LIMIT  = 10;
   localparam logic [63:0] PI_FIX   = 64'h3243F6A8885A308D;
   localparam logic [63:0] UNIT_Q60 = 64'd1 << 60;

   typedef struct packed {
      logic [MID_W-1:0]  mid_x;
      logic [MID_W-1:0]  mid_y;
      logic [HEAD_W-1:0] heading;
      logic              valid;
   } pose_type;

   // one directed row; known marks a result typed in by hand
   typedef struct packed {
      logic [15:0] fx;
      logic [15:0] fy;
      logic [15:0] bx;
      logic [15:0] by;
      logic        known;
      pose_type    pose;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [HEIGHT_W-1:0] csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   // front_x, front_y, back_x, back_y
   logic [REQ_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // mid_x, mid_y, heading_deg, zero fill
   logic [RSP_W-1:0]    rsp_tdata;
   // pose_valid
   logic                rsp_tuser;

   logic [63:0]   sin_q [1:DEG_CELLS];
   logic [63:0]   cos_q [1:DEG_CELLS];
   pose_type      pose_q [$];
   logic [11:0]   cur_height;
   logic [11:0]   phase_heights [PHASES];
   dir_row_type   dir_rows [DIR_ROWS];
   bit            seen_deg [0:359];
   int unsigned   cycle_cnt;
   int unsigned   fail_cnt;
   int unsigned   sent_cnt;
   int unsigned   checked_cnt;
   int unsigned   coincident_cnt;
   int unsigned   burst_left;

   two_marker_pose_heading_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Q60 product, upper bits kept
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 60);
   endfunction

   // sin/cos of each whole degree 1..44, Taylor series, rounded to the trig grid
   task automatic build_degree_table;
      logic [63:0] stepv;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] s;
      logic [63:0] c;
      stepv = PI_FIX / 64'd180;
      for (int k = 1; k <= DEG_CELLS; k++) begin
         x  = stepv * 64'(k);
         x2 = q60_mul(x, x);
         ts = x;
         tc = UNIT_Q60;
         s  = x;
         c  = UNIT_Q60;
         for (int i = 1; i <= 12; i++) begin
            ts = q60_mul(ts, x2) / 64'((2 * i) * (2 * i + 1));
            tc = q60_mul(tc, x2) / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
               s = s - ts;
               c = c - tc;
            end else begin
               s = s + ts;
               c = c + tc;
            end
         end
         sin_q[k] = (s + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
         cos_q[k] = (c + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
      end
   endtask

   // largest whole degree not above atan(n/m), for 0 <= n <= m
   function automatic int unsigned octant_degree(input logic [63:0] n, input logic [63:0] m);
      int unsigned f;
      f = 0;
      if (n >= m)
         return 45;
      for (int k = 1; k <= DEG_CELLS; k++)
         if (n * cos_q[k] >= m * sin_q[k])
            f = k;
      return f;
   endfunction

   function automatic pose_type predict_pose(input logic [15:0] fx_i, input logic [15:0] fy_i,
                                             input logic [15:0] bx_i, input logic [15:0] by_i,
                                             input logic [11:0] hgt);
      longint      fx;
      longint      fy;
      longint      bx;
      longint      by;
      longint      h;
      longint      dx;
      longint      dy;
      longint      ysum;
      logic [63:0] a;
      logic [63:0] b;
      int unsigned f;
      int unsigned g;
      int unsigned hd;
      bit          exact;
      pose_type    p;
      fx = fx_i;
      fy = fy_i;
      bx = bx_i;
      by = by_i;
      h  = hgt;
      h  = h * (1 << FRAC_BITS);
      dx = fx - bx;
      dy = by - fy;
      ysum = 2 * h - fy - by;
      p.mid_x = MID_W'((fx + bx) >> (FRAC_BITS + 1));
      p.mid_y = (ysum < 0) ? '0 : MID_W'(ysum >> (FRAC_BITS + 1));
      a = (dx < 0) ? -dx : dx;
      b = (dy < 0) ? -dy : dy;
      p.heading = '0;
      p.valid   = 1'b1;
      if (a == 0 && b == 0) begin
         p.valid = 1'b0;
      end else begin
         // fold into the first octant, then unfold by quadrant
         if (b <= a) begin
            f = octant_degree(b, a);
            exact = (b == 0) || (b == a);
         end else begin
            g = octant_degree(a, b);
            exact = (a == 0);
            f = exact ? 90 - g : 89 - g;
         end
         if (dx > 0 && dy >= 0)
            hd = f;
         else if (dx <= 0 && dy > 0)
            hd = exact ? 180 - f : 179 - f;
         else if (dx < 0 && dy <= 0)
            hd = 180 + f;
         else
            hd = exact ? 360 - f : 359 - f;
         p.heading = HEAD_W'(hd);
      end
      return p;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0)
         return 0;
      if (v > 65535)
         return 65535;
      return v;
   endfunction

   // random centroid pair, shaped to cover all headings and the flip edge
   task automatic pick_coords(output logic [15:0] fx, output logic [15:0] fy,
                              output logic [15:0] bx, output logic [15:0] by);
      int mode;
      int cx;
      int cy;
      int ddx;
      int ddy;
      int d;
      int dir;
      int hy;
      mode = $urandom_range(0, 99);
      ddx = 0;
      ddy = 0;
      cx  = $urandom_range(0, 65535);
      cy  = $urandom_range(0, 65535);
      if (mode < 35) begin
         ddx = int'($urandom_range(0, 65535)) - cx;
         ddy = int'($urandom_range(0, 65535)) - cy;
      end else if (mode < 65) begin
         cx  = $urandom_range(256, 65279);
         cy  = $urandom_range(256, 65279);
         ddx = int'($urandom_range(0, 511)) - 256;
         ddy = int'($urandom_range(0, 511)) - 256;
      end else if (mode < 75) begin
         cx  = $urandom_range(4096, 61439);
         cy  = $urandom_range(4096, 61439);
         ddx = int'($urandom_range(0, 8191)) - 4096;
         ddy = int'($urandom_range(0, 8191)) - 4096;
      end else if (mode < 90 && mode >= 82) begin
         // exact axes and diagonals
         cx  = $urandom_range(8192, 57343);
         cy  = $urandom_range(8192, 57343);
         d   = $urandom_range(1, 8000);
         dir = $urandom_range(0, 7);
         ddx = (dir == 0 || dir == 1 || dir == 7) ? d : (dir >= 3 && dir <= 5) ? -d : 0;
         ddy = (dir >= 1 && dir <= 3) ? d : (dir >= 5) ? -d : 0;
      end else if (mode >= 90) begin
         // y close to the image height so the flipped sum nears zero
         hy  = int'(cur_height) * (1 << FRAC_BITS);
         cy  = clamp_coord(hy + int'($urandom_range(0, 128)) - 64);
         ddy = clamp_coord(hy + int'($urandom_range(0, 128)) - 64) - cy;
         ddx = int'($urandom_range(0, 65535)) - cx;
      end
      // mode 75..81 leaves both deltas at zero: coincident tags
      bx = 16'(cx);
      by = 16'(cy);
      fx = 16'(cx + ddx);
      fy = 16'(cy + ddy);
   endtask

   // one input transfer; starts and ends at a falling edge, valid left high
   task automatic send_item(input logic [15:0] fx, input logic [15:0] fy,
                            input logic [15:0] bx, input logic [15:0] by,
                            input logic known, input pose_type typed);
      int unsigned g;
      pose_type    want;
      if (burst_left > 0) begin
         burst_left--;
         g = 0;
      end else begin
         if ($urandom_range(0, 99) < 3)
            burst_left = $urandom_range(30, 80);
         g = idle_len();
      end
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tdata  <= {by, bx, fy, fx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      want = known ? typed : predict_pose(fx, fy, bx, by, cur_height);
      pose_q.push_back(want);
      sent_cnt++;
      if (!want.valid)
         coincident_cnt++;
      @(negedge clock);
   endtask

   // new image height, written only once the pipeline is empty
   task automatic write_height(input logic [11:0] v);
      req_tvalid <= 1'b0;
      while (pose_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we     <= 1'b0;
      cur_height = v;
   endtask

   task automatic report_mismatch(input pose_type want, input pose_type got, input bit orphan);
      fail_cnt++;
      if (fail_cnt <= SHOW_LIMIT) begin
         if (orphan)
            $display("unexpected result at cycle %0d: mid_x=%0d mid_y=%0d heading=%0d valid=%0d",
                     cycle_cnt, got.mid_x, got.mid_y, got.heading, got.valid);
         else
            $display("mismatch at cycle %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     cycle_cnt, want.mid_x, want.mid_y, want.heading, want.valid,
                     got.mid_x, got.mid_y, got.heading, got.valid);
      end
   endtask

   // result receiver: ready runs and stalls of random length
   initial begin
      int unsigned run;
      int unsigned g;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         run = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         g = idle_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   // result check against the oldest pending pose
   always @(posedge clock) begin
      pose_type got;
      pose_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.mid_x   = rsp_tdata[MID_W-1:0];
         got.mid_y   = rsp_tdata[2*MID_W-1:MID_W];
         got.heading = rsp_tdata[2*MID_W+HEAD_W-1:2*MID_W];
         got.valid   = rsp_tuser;
         if (pose_q.size() == 0) begin
            report_mismatch(got, got, 1'b1);
         end else begin
            want = pose_q.pop_front();
            checked_cnt++;
            if (got.mid_x !== want.mid_x || got.mid_y !== want.mid_y ||
                got.heading !== want.heading || got.valid !== want.valid)
               report_mismatch(want, got, 1'b0);
            if (got.valid === 1'b1 && got.heading < 360)
               seen_deg[got.heading] = 1'b1;
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_cnt, pose_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [15:0] fx;
      logic [15:0] fy;
      logic [15:0] bx;
      logic [15:0] by;
      int unsigned deg_cnt;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      cycle_cnt      = 0;
      fail_cnt       = 0;
      sent_cnt       = 0;
      checked_cnt    = 0;
      coincident_cnt = 0;
      burst_left     = 0;
      cur_height     = 12'd480;
      build_degree_table();

      // directed rows at the reset height: fx, fy, bx, by, known, expected pose
      dir_rows = '{
         '{16'd0,     16'd0,     16'd0,     16'd0,     1'b1, '{12'd0,    12'd480, 9'd0,   1'b0}},
         '{16'd16,    16'd0,     16'd0,     16'd0,     1'b1, '{12'd0,    12'd480, 9'd0,   1'b1}},
         '{16'd0,     16'd0,     16'd0,     16'd16,    1'b1, '{12'd0,    12'd479, 9'd90,  1'b1}},
         '{16'd0,     16'd0,     16'd16,    16'd0,     1'b1, '{12'd0,    12'd480, 9'd180, 1'b1}},
         '{16'd0,     16'd16,    16'd0,     16'd0,     1'b1, '{12'd0,    12'd479, 9'd270, 1'b1}},
         '{16'd16,    16'd0,     16'd0,     16'd16,    1'b1, '{12'd0,    12'd479, 9'd45,  1'b1}},
         '{16'd0,     16'd0,     16'd16,    16'd16,    1'b1, '{12'd0,    12'd479, 9'd135, 1'b1}},
         '{16'd0,     16'd16,    16'd16,    16'd0,     1'b1, '{12'd0,    12'd479, 9'd225, 1'b1}},
         '{16'd16,    16'd16,    16'd0,     16'd0,     1'b1, '{12'd0,    12'd479, 9'd315, 1'b1}},
         '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1, '{12'd4095, 12'd0,   9'd0,   1'b0}},
         '{16'd65535, 16'd0,     16'd0,     16'd0,     1'b1, '{12'd2047, 12'd480, 9'd0,   1'b1}},
         '{16'd7680,  16'd7680,  16'd7680,  16'd7680,  1'b1, '{12'd480,  12'd0,   9'd0,   1'b0}},
         '{16'd0,     16'd65535, 16'd65535, 16'd0,     1'b0, '0},
         '{16'd65535, 16'd0,     16'd0,     16'd1,     1'b0, '0},
         '{16'd1,     16'd0,     16'd0,     16'd65535, 1'b0, '0},
         '{16'd0,     16'd65535, 16'd1,     16'd0,     1'b0, '0},
         '{16'd65535, 16'd1,     16'd0,     16'd0,     1'b0, '0},
         '{16'd3,     16'd0,     16'd0,     16'd1,     1'b0, '0},
         '{16'h5555,  16'hAAAA,  16'hAAAA,  16'h5555,  1'b0, '0},
         '{16'hAAAA,  16'h5555,  16'h5555,  16'hAAAA,  1'b0, '0},
         '{16'd7680,  16'd7679,  16'd7680,  16'd7681,  1'b0, '0}
      };

      // extremes first, then random heights, then back to the reset value
      phase_heights[0] = 12'd4095;
      phase_heights[1] = 12'd1;
      phase_heights[2] = 12'd0;
      phase_heights[3] = 12'($urandom_range(1, 4095));
      phase_heights[4] = 12'($urandom_range(1, 4095));
      phase_heights[5] = 12'd480;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIR_ROWS; r++)
         send_item(dir_rows[r].fx, dir_rows[r].fy, dir_rows[r].bx, dir_rows[r].by,
                   dir_rows[r].known, dir_rows[r].pose);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_height(phase_heights[ph]);
         repeat (PHASE_ITEMS) begin
            pick_coords(fx, fy, bx, by);
            send_item(fx, fy, bx, by, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then watch a while longer for stray results
      while (pose_q.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      deg_cnt = 0;
      for (int k = 0; k < 360; k++)
         deg_cnt += seen_deg[k];
      $display("covered %0d transfers (%0d checked) under %0d image heights plus reset",
               sent_cnt, checked_cnt, PHASES);
      $display("headings hit: %0d of 360 degrees, coincident poses: %0d, failures: %0d",
               deg_cnt, coincident_cnt, fail_cnt);
      if (fail_cnt == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
